FILE: sv/sorted_free_space_table_unit_defines.svh
// Assertion macros used by the sorted free-space table sequencer.
// No dependencies; the asserting module must provide clk and arst_n.
`ifndef SORTED_FREE_SPACE_TABLE_UNIT_DEFINES_SVH
`define SORTED_FREE_SPACE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sfst_pkg.sv
// Package for the sorted free-space table: widths, function codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package sfst_pkg;

	localparam int SLOT_W  = 9;
	localparam int POS_W   = 8;
	localparam int AMT_W   = 16;
	localparam int PID_W   = 16;
	localparam int FUNC_W  = 2;
	localparam int FIRST_W = 8;
	localparam int END_W   = 9;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Function codes of a command transaction.
	localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [POS_W-1:0]  position;
		logic [AMT_W-1:0]  amount;
		logic [PID_W-1:0]  page_id;
	} sfst_in_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] slot;
		logic [PID_W-1:0] found_page;
	} sfst_out_t;

	typedef struct packed {
		logic [FIRST_W-1:0] first_slot;
		logic [END_W-1:0]   end_slot;
	} sfst_cfg_t;

	// Table access issued by the sequencer; addresses are slot indexes.
	typedef struct packed {
		logic              we_amt;
		logic              we_pid;
		logic [SLOT_W-1:0] waddr;
		logic [AMT_W-1:0]  wamt;
		logic [PID_W-1:0]  wpid;
		logic [SLOT_W-1:0] raddr;
	} sfst_mem_req_t;

	typedef struct packed {
		logic [AMT_W-1:0] amt;
		logic [PID_W-1:0] pid;
	} sfst_mem_rsp_t;

	// Outputs of the shared compare and midpoint unit.
	typedef struct packed {
		logic              lt;
		logic              gt;
		logic              lo_lt_hi;
		logic [SLOT_W-1:0] mid_up;
		logic [SLOT_W-1:0] mid_dn;
	} sfst_cmp_t;

endpackage

FILE: sv/sfst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sfst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; a read of the written address returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/sfst_cmp.sv
// Shared compare and midpoint unit used by every search step of the sequencer.
// Depends on sfst_pkg.
`timescale 1ns / 1ps

module sfst_cmp (
	input  logic [sfst_pkg::SLOT_W-1:0] lo,
	input  logic [sfst_pkg::SLOT_W-1:0] hi,
	input  logic [sfst_pkg::AMT_W-1:0]  rd_amt,
	input  logic [sfst_pkg::AMT_W-1:0]  key,
	output sfst_pkg::sfst_cmp_t         res
);

	import sfst_pkg::*;

	logic [SLOT_W:0] sum;
	logic [SLOT_W:0] sum_up;

	// Midpoints rounded down and up over the current search window.
	assign sum    = {1'b0, lo} + {1'b0, hi};
	assign sum_up = sum + {{SLOT_W{1'b0}}, 1'b1};

	// One magnitude comparison of the table word against the key.
	always_comb begin
		res.lt       = rd_amt < key;
		res.gt       = rd_amt > key;
		res.lo_lt_hi = lo < hi;
		res.mid_dn   = sum[SLOT_W:1];
		res.mid_up   = sum_up[SLOT_W:1];
	end

endmodule

FILE: sv/sfst_regs.sv
// APB-style configuration registers: first slot and end slot of the sorted range.
// Depends on sfst_pkg.
`timescale 1ns / 1ps

module sfst_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sfst_pkg::PADDR_W-1:0] paddr,
	input  logic [sfst_pkg::PDATA_W-1:0] pwdata,
	output logic [sfst_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output sfst_pkg::sfst_cfg_t          cfg
);

	import sfst_pkg::*;

	localparam logic REG_FIRST_SLOT = 1'b0;
	localparam logic REG_END_SLOT   = 1'b1;

	sfst_cfg_t cfg_q;
	logic      wr_c;
	logic      sel_c;

	assign wr_c   = psel && penable && pwrite;
	assign sel_c  = paddr[PADDR_W-1];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register write in the access phase of a transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_c) begin
			case (sel_c)
				REG_FIRST_SLOT: cfg_q.first_slot <= pwdata[FIRST_W-1:0];
				REG_END_SLOT:   cfg_q.end_slot   <= pwdata[END_W-1:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// Read data, zero-extended to the bus width.
	always_comb begin
		case (sel_c)
			REG_FIRST_SLOT: prdata = PDATA_W'(cfg_q.first_slot);
			REG_END_SLOT:   prdata = PDATA_W'(cfg_q.end_slot);
			default:        prdata = '0;
		endcase
	end

endmodule

FILE: sv/sfst_ctrl.sv
// Sequencer of the sorted free-space table: binary searches and one-place shifts.
// Depends on sfst_pkg, sfst_cmp and the assertion macros header.
`timescale 1ns / 1ps
`include "sorted_free_space_table_unit_defines.svh"

module sfst_ctrl #(
	parameter int DEPTH = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  sfst_pkg::sfst_in_t      cmd,
	output logic                    done,
	output sfst_pkg::sfst_out_t     result,
	input  sfst_pkg::sfst_cfg_t     cfg,
	output sfst_pkg::sfst_mem_req_t mem_req,
	input  sfst_pkg::sfst_mem_rsp_t mem_rsp
);

	import sfst_pkg::*;

	localparam logic [SLOT_W-1:0] SLOT_ONE = SLOT_W'(1);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SRCH_HEAD,
		ST_SRCH_CHK,
		ST_SRCH_LOOP,
		ST_SRCH_CMP,
		ST_SRCH_PAGE,
		ST_UPD_WR,
		ST_UPD_PID,
		ST_UP_CHK,
		ST_DN_TEST,
		ST_DN_CHK,
		ST_UP_LOOP,
		ST_UP_CMP,
		ST_DN_LOOP,
		ST_DN_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR
	} state_t;

	state_t            state_q;
	logic              done_q;
	sfst_out_t         result_q;
	logic [AMT_W-1:0]  key_q;
	logic [PID_W-1:0]  pid_q;
	logic [SLOT_W-1:0] pos_q;
	logic [SLOT_W-1:0] lo_q;
	logic [SLOT_W-1:0] hi_q;
	logic [SLOT_W-1:0] mid_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] tgt_q;
	logic              dir_up_q;

	logic [SLOT_W-1:0] head_c;
	logic [SLOT_W-1:0] tail_c;
	logic [SLOT_W-1:0] src_c;
	logic              pos_ok_c;
	sfst_cmp_t         cmp;

	// Range bounds, with the end clamped to the table depth.
	assign head_c   = {1'b0, cfg.first_slot};
	assign tail_c   = (32'(cfg.end_slot) > 32'(DEPTH)) ? SLOT_W'(DEPTH) : cfg.end_slot;
	assign pos_ok_c = 32'(cmd.position) < 32'(DEPTH);
	assign src_c    = dir_up_q ? (idx_q - SLOT_ONE) : (idx_q + SLOT_ONE);

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

	sfst_cmp u_cmp (
		.lo     (lo_q),
		.hi     (hi_q),
		.rd_amt (mem_rsp.amt),
		.key    (key_q),
		.res    (cmp)
	);

	// Table reads and writes decoded from the current step.
	always_comb begin
		mem_req        = '0;
		mem_req.raddr  = lo_q;
		case (state_q)
			ST_SRCH_HEAD: mem_req.raddr = head_c;
			ST_SRCH_LOOP: mem_req.raddr = cmp.lo_lt_hi ? cmp.mid_up : lo_q;
			ST_WRITE: begin
				mem_req.we_amt = 1'b1;
				mem_req.we_pid = 1'b1;
				mem_req.waddr  = pos_q;
				mem_req.wamt   = key_q;
				mem_req.wpid   = pid_q;
			end
			ST_UPD_WR: begin
				mem_req.we_amt = 1'b1;
				mem_req.waddr  = pos_q;
				mem_req.wamt   = key_q;
				mem_req.raddr  = pos_q;
			end
			ST_UPD_PID: mem_req.raddr = pos_q - SLOT_ONE;
			ST_DN_TEST: mem_req.raddr = pos_q + SLOT_ONE;
			ST_UP_LOOP: mem_req.raddr = cmp.mid_dn;
			ST_DN_LOOP: mem_req.raddr = cmp.mid_up;
			ST_SHIFT_RD: begin
				if (idx_q != tgt_q) begin
					mem_req.raddr = src_c;
				end else begin
					mem_req.we_amt = 1'b1;
					mem_req.we_pid = 1'b1;
					mem_req.waddr  = tgt_q;
					mem_req.wamt   = key_q;
					mem_req.wpid   = pid_q;
				end
			end
			ST_SHIFT_WR: begin
				mem_req.we_amt = 1'b1;
				mem_req.we_pid = 1'b1;
				mem_req.waddr  = idx_q;
				mem_req.wamt   = mem_rsp.amt;
				mem_req.wpid   = mem_rsp.pid;
			end
			default: mem_req.raddr = lo_q;
		endcase
	end

	// Sequencer state, search window and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
			key_q    <= '0;
			pid_q    <= '0;
			pos_q    <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			mid_q    <= '0;
			idx_q    <= '0;
			tgt_q    <= '0;
			dir_up_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						key_q <= cmd.amount;
						pid_q <= cmd.page_id;
						pos_q <= {1'b0, cmd.position};
						case (cmd.func)
							FUNC_SEARCH: state_q <= ST_SRCH_HEAD;
							FUNC_UPDATE: begin
								if (pos_ok_c) begin
									state_q <= ST_UPD_WR;
								end else begin
									done_q   <= 1'b1;
									result_q <= '0;
								end
							end
							FUNC_WRITE: begin
								if (pos_ok_c) begin
									state_q <= ST_WRITE;
								end else begin
									done_q   <= 1'b1;
									result_q <= '0;
								end
							end
							default: begin
								done_q   <= 1'b1;
								result_q <= '0;
							end
						endcase
					end
				end
				ST_WRITE: begin
					done_q   <= 1'b1;
					result_q <= '{found: 1'b0, slot: pos_q[POS_W-1:0], found_page: pid_q};
					state_q  <= ST_IDLE;
				end
				// Search: an empty range or a too-small first entry finds nothing.
				ST_SRCH_HEAD: begin
					if (head_c >= tail_c) begin
						done_q   <= 1'b1;
						result_q <= '0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_SRCH_CHK;
					end
				end
				ST_SRCH_CHK: begin
					if (cmp.lt) begin
						done_q   <= 1'b1;
						result_q <= '0;
						state_q  <= ST_IDLE;
					end else begin
						lo_q    <= head_c;
						hi_q    <= tail_c - SLOT_ONE;
						state_q <= ST_SRCH_LOOP;
					end
				end
				ST_SRCH_LOOP: begin
					if (cmp.lo_lt_hi) begin
						mid_q   <= cmp.mid_up;
						state_q <= ST_SRCH_CMP;
					end else begin
						state_q <= ST_SRCH_PAGE;
					end
				end
				ST_SRCH_CMP: begin
					if (!cmp.lt) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= cmp.mid_dn;
					end
					state_q <= ST_SRCH_LOOP;
				end
				ST_SRCH_PAGE: begin
					done_q   <= 1'b1;
					result_q <= '{found: 1'b1, slot: lo_q[POS_W-1:0], found_page: mem_rsp.pid};
					state_q  <= ST_IDLE;
				end
				// Update: the new amount is written, then the entry's page is fetched.
				ST_UPD_WR: state_q <= ST_UPD_PID;
				ST_UPD_PID: begin
					pid_q   <= mem_rsp.pid;
					state_q <= (head_c < pos_q) ? ST_UP_CHK : ST_DN_TEST;
				end
				ST_UP_CHK: begin
					if (cmp.lt) begin
						lo_q    <= head_c;
						hi_q    <= pos_q - SLOT_ONE;
						state_q <= ST_UP_LOOP;
					end else begin
						state_q <= ST_DN_TEST;
					end
				end
				ST_DN_TEST: begin
					if ((pos_q + SLOT_ONE) < tail_c) begin
						state_q <= ST_DN_CHK;
					end else begin
						done_q   <= 1'b1;
						result_q <= '{found: 1'b0, slot: pos_q[POS_W-1:0], found_page: pid_q};
						state_q  <= ST_IDLE;
					end
				end
				ST_DN_CHK: begin
					if (cmp.gt) begin
						lo_q    <= pos_q + SLOT_ONE;
						hi_q    <= tail_c - SLOT_ONE;
						state_q <= ST_DN_LOOP;
					end else begin
						done_q   <= 1'b1;
						result_q <= '{found: 1'b0, slot: pos_q[POS_W-1:0], found_page: pid_q};
						state_q  <= ST_IDLE;
					end
				end
				// Upward move: find the first slot holding less than the new amount.
				ST_UP_LOOP: begin
					if (cmp.lo_lt_hi) begin
						mid_q   <= cmp.mid_dn;
						state_q <= ST_UP_CMP;
					end else begin
						idx_q    <= pos_q;
						tgt_q    <= hi_q;
						dir_up_q <= 1'b1;
						state_q  <= ST_SHIFT_RD;
					end
				end
				ST_UP_CMP: begin
					if (cmp.lt) begin
						hi_q <= mid_q;
					end else begin
						lo_q <= cmp.mid_up;
					end
					state_q <= ST_UP_LOOP;
				end
				// Downward move: find the last slot holding more than the new amount.
				ST_DN_LOOP: begin
					if (cmp.lo_lt_hi) begin
						mid_q   <= cmp.mid_up;
						state_q <= ST_DN_CMP;
					end else begin
						idx_q    <= pos_q;
						tgt_q    <= lo_q;
						dir_up_q <= 1'b0;
						state_q  <= ST_SHIFT_RD;
					end
				end
				ST_DN_CMP: begin
					if (cmp.gt) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= cmp.mid_dn;
					end
					state_q <= ST_DN_LOOP;
				end
				// Shift neighbours one place, then drop the moved entry at its target.
				ST_SHIFT_RD: begin
					if (idx_q != tgt_q) begin
						state_q <= ST_SHIFT_WR;
					end else begin
						done_q   <= 1'b1;
						result_q <= '{found: 1'b0, slot: tgt_q[POS_W-1:0], found_page: pid_q};
						state_q  <= ST_IDLE;
					end
				end
				ST_SHIFT_WR: begin
					idx_q   <= src_c;
					state_q <= ST_SHIFT_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SFST_ASSERT_NXT(a_accept_progress, start && !busy, busy || done, "accepted command made no progress")
	`SFST_ASSERT_NXT(a_done_single, done && !(start && !busy), !done, "done held too long")
	`SFST_ASSERT_IMP(a_write_when_busy, mem_req.we_amt || mem_req.we_pid, busy, "table written while idle")
	`SFST_ASSERT_IMP(a_pid_with_amt, mem_req.we_pid, mem_req.we_amt, "page written without its amount")

endmodule

FILE: sv/sorted_free_space_table_unit.sv
// Top level of the sorted free-space table: registers, sequencer and table memories.
// Depends on sfst_pkg, sfst_regs, sfst_ctrl and sfst_ram.
`timescale 1ns / 1ps

// Usage
// A command transaction is taken at a clock edge with start high and busy low; cmd
// carries func, position, amount and page_id. busy stays high while the command runs.
// Each command gives exactly one result, shown on result for one cycle with done high.
// The receiver cannot hold a result off; it must take it in that cycle.
// Command timing is set by the one shared comparator and the registered read of the
// table memory: each search step and each shift costs one read and one use. A search
// makes at most ceil(log2(range length)) search steps; an unused function code or a
// position beyond the table finishes without any table access.
// busy drops in the cycle that done is shown, so the next command can be taken then.
// The user must write the configuration registers over the APB-style port only while idle;
// the block itself does not enforce it. Reset clears first_slot, end_slot and the sequencer;
// the table contents are undefined until written and are not cleared, so no clearing pass follows reset.
module sorted_free_space_table_unit #(
	parameter int DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  sfst_pkg::sfst_in_t           cmd,
	output logic                         done,
	output sfst_pkg::sfst_out_t          result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sfst_pkg::PADDR_W-1:0] paddr,
	input  logic [sfst_pkg::PDATA_W-1:0] pwdata,
	output logic [sfst_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	import sfst_pkg::*;

	localparam int AW = $clog2(DEPTH);

	sfst_cfg_t     cfg;
	sfst_mem_req_t mem_req;
	sfst_mem_rsp_t mem_rsp;

	sfst_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfst_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.cfg     (cfg),
		.mem_req (mem_req),
		.mem_rsp (mem_rsp)
	);

	// Free amounts of the table.
	sfst_ram #(
		.WIDTH (AMT_W),
		.DEPTH (DEPTH)
	) u_amt_ram (
		.clk   (clk),
		.we    (mem_req.we_amt),
		.waddr (AW'(mem_req.waddr)),
		.wdata (mem_req.wamt),
		.raddr (AW'(mem_req.raddr)),
		.rdata (mem_rsp.amt)
	);

	// Page identifiers of the table.
	sfst_ram #(
		.WIDTH (PID_W),
		.DEPTH (DEPTH)
	) u_pid_ram (
		.clk   (clk),
		.we    (mem_req.we_pid),
		.waddr (AW'(mem_req.waddr)),
		.wdata (mem_req.wpid),
		.raddr (AW'(mem_req.raddr)),
		.rdata (mem_rsp.pid)
	);

endmodule
